@@ sv/vtx_pkg.sv @@
`timescale 1ns / 1ps
// package for the vertex transform block
// shared constants, item types and the front-to-back queue entry
package vtx_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW = 32;
    localparam int CFGW = 12;
    localparam int QDIV_W = DW + FRAC_BITS + 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam logic CFG_HALF_WIDTH = 1'b0;
    localparam logic CFG_HALF_HEIGHT = 1'b1;

    localparam logic [CFGW-1:0] HW_RESET = 12'd400;
    localparam logic [CFGW-1:0] HH_RESET = 12'd300;

    localparam logic signed [DW-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [DW-1:0] tx;
        logic signed [DW-1:0] ty;
        logic signed [DW-1:0] tz;
        logic signed [DW-1:0] tw;
    } vtx_xf_t;

    function automatic logic signed [DW-1:0] sat_w(input logic signed [71:0] v);
        if (v > 72'sh0_7fffffff)
        begin
            return S32_MAX;
        end
        else if (v < -72'sh0_80000000)
        begin
            return S32_MIN;
        end
        return v[DW-1:0];
    endfunction

endpackage

@@ sv/vertex_transform_project_top.sv @@
`timescale 1ns / 1ps
// Vertex transform block: a load item (tuser 0) writes one matrix entry, a vertex item
// (tuser 1) gives one result. One item is accepted per cycle unless the output stalls; a
// vertex result passes through two matrix product stages, the divider input register, the
// 50-stage pipelined divider and two scaling stages. A stalled result holds the whole
// pipeline. Depends on vtx_pkg, vtx_front and vtx_back.
module vertex_transform_project_top
    import vtx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // entry_index, entry_value, vertex_x, vertex_y, vertex_z, vertex_w
    input  logic [167:0]  s_axis_tdata,
    // command
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // screen_x, screen_y, depth_z, clip_w, w_zero
    output logic [135:0]  m_axis_tdata,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [CFGW-1:0] cfg_data
);

    logic [CFGW-1:0] hw_reg, hh_reg;
    logic q_valid, q_ready;
    vtx_xf_t q_data;
    logic [4*DW:0] od;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= HW_RESET;
            hh_reg <= HH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HALF_WIDTH)
            begin
                hw_reg <= cfg_data;
            end
            else
            begin
                hh_reg <= cfg_data;
            end
        end
    end

    vtx_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .command(s_axis_tuser),
        .entry_index(s_axis_tdata[3:0]),
        .entry_value(s_axis_tdata[35:4]),
        .vx(s_axis_tdata[67:36]), .vy(s_axis_tdata[99:68]),
        .vz(s_axis_tdata[131:100]), .vw(s_axis_tdata[163:132]),
        .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready)
    );

    vtx_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready),
        .half_width(hw_reg), .half_height(hh_reg),
        .out_valid(m_axis_tvalid), .out_data(od), .out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, od};

endmodule

@@ sv/vtx_front.sv @@
`timescale 1ns / 1ps
// front part: accepts items, holds the matrix, computes the matrix product
// pipelined: products, sum, floor shift and saturation, then pushes into the queue; uses vtx_pkg
module vtx_front
    import vtx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [3:0]           entry_index,
    input  logic signed [DW-1:0] entry_value,
    input  logic signed [DW-1:0] vx,
    input  logic signed [DW-1:0] vy,
    input  logic signed [DW-1:0] vz,
    input  logic signed [DW-1:0] vw,
    output logic                 q_valid,
    output vtx_xf_t              q_data,
    input  logic                 q_ready
);

    logic signed [DW-1:0] m_reg [16];
    logic signed [2*DW-1:0] p_reg [16];
    logic s1_reg, s2_reg;
    vtx_xf_t s2_data_reg;
    logic adv;
    logic signed [DW-1:0] v [4];
    logic signed [71:0] sums [4];
    logic signed [DW-1:0] res [4];

    // pipeline advances when the output slot is free
    assign adv = !s2_reg || q_ready;
    assign in_ready = adv;
    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;
    assign v[3] = vw;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sums[r] = 72'(p_reg[r*4]) + 72'(p_reg[r*4+1]) + 72'(p_reg[r*4+2])
                    + 72'(p_reg[r*4+3]);
            res[r] = sat_w(sums[r] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                m_reg[i] <= (i % 5 == 0) ? DW'(1 << FRAC_BITS) : '0;
            end
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg <= in_valid && command == CMD_VERTEX;
            s2_reg <= s1_reg;
            if (in_valid && command == CMD_LOAD)
            begin
                m_reg[entry_index] <= entry_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 16; i++)
            begin
                p_reg[i] <= m_reg[i] * v[i % 4];
            end
            s2_data_reg <= '{tx: res[0], ty: res[1], tz: res[2], tw: res[3]};
        end
    end

    assign q_valid = s2_reg;
    assign q_data = s2_data_reg;

    property p_hold;
        @(posedge clk) disable iff (!rst_n) q_valid && !q_ready |=> q_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("queue entry dropped");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> in_ready) else $error("stall without full output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> $stable(q_data)) else $error("data changed on stall");

endmodule

@@ sv/vtx_back.sv @@
`timescale 1ns / 1ps
// back part: divides x and y by w (pipelined restoring divider), scales to screen
// one quotient bit per stage, one item per cycle unless the output stalls; uses vtx_pkg
module vtx_back
    import vtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  vtx_xf_t               q_data,
    output logic                  q_ready,
    input  logic [CFGW-1:0]       half_width,
    input  logic [CFGW-1:0]       half_height,
    output logic                  out_valid,
    output logic [4*DW:0]         out_data,
    input  logic                  out_ready
);

    localparam int NS = QDIV_W;
    localparam int UW = QDIV_W;
    localparam int RW = DW + 1;

    typedef struct packed {
        logic [UW-1:0] nx;
        logic [UW-1:0] ny;
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic [RW-1:0] d;
        logic negx;
        logic negy;
        logic wz;
        logic signed [DW-1:0] tz;
        logic signed [DW-1:0] tw;
    } div_t;

    div_t st_reg [NS+1];
    logic vld_reg [NS+3];
    logic adv;
    div_t st_in;
    div_t st_nx [NS];
    logic [UW-1:0] ax, ay;
    logic [DW-1:0] aw;
    logic signed [DW-1:0] qx, qy;
    logic signed [71:0] sx, sy;
    logic [4*DW:0] res_reg;
    logic signed [DW-1:0] qx_reg, qy_reg;
    div_t fin_reg;

    assign adv = !vld_reg[NS+2] || out_ready;
    assign q_ready = adv;

    always_comb
    begin
        ax = q_data.tx[DW-1] ? UW'(-{{(UW-DW){1'b1}}, q_data.tx}) << FRAC_BITS
                             : UW'(q_data.tx) << FRAC_BITS;
        ay = q_data.ty[DW-1] ? UW'(-{{(UW-DW){1'b1}}, q_data.ty}) << FRAC_BITS
                             : UW'(q_data.ty) << FRAC_BITS;
        aw = q_data.tw[DW-1] ? DW'(-q_data.tw) : DW'(q_data.tw);
        st_in = '0;
        st_in.nx = ax;
        st_in.ny = ay;
        st_in.d = {1'b0, aw};
        st_in.negx = q_data.tx[DW-1] ^ q_data.tw[DW-1];
        st_in.negy = q_data.ty[DW-1] ^ q_data.tw[DW-1];
        st_in.wz = q_data.tw == '0;
        st_in.tz = q_data.tz;
        st_in.tw = q_data.tw;
    end

    // one quotient bit per stage, remainder in rx/ry, dividend and quotient shift through nx/ny
    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            logic [RW-1:0] trx, try_;
            st_nx[s] = st_reg[s];
            trx = {st_reg[s].rx[RW-2:0], st_reg[s].nx[UW-1]};
            try_ = {st_reg[s].ry[RW-2:0], st_reg[s].ny[UW-1]};
            st_nx[s].nx = {st_reg[s].nx[UW-2:0], trx >= st_reg[s].d};
            st_nx[s].ny = {st_reg[s].ny[UW-2:0], try_ >= st_reg[s].d};
            st_nx[s].rx = trx >= st_reg[s].d ? trx - st_reg[s].d : trx;
            st_nx[s].ry = try_ >= st_reg[s].d ? try_ - st_reg[s].d : try_;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS + 3; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= q_valid;
            for (int s = 1; s < NS + 3; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_comb
    begin
        logic signed [UW:0] sqx, sqy;
        sqx = st_reg[NS].negx ? -$signed({1'b0, st_reg[NS].nx})
                              : $signed({1'b0, st_reg[NS].nx});
        sqy = st_reg[NS].negy ? -$signed({1'b0, st_reg[NS].ny})
                              : $signed({1'b0, st_reg[NS].ny});
        qx = sat_w(72'(sqx));
        qy = sat_w(72'(sqy));
        sx = 72'($signed({1'b0, half_width})) <<< FRAC_BITS;
        sx = sx + 72'(qx_reg) * 72'($signed({1'b0, half_width}));
        sy = 72'($signed({1'b0, half_height})) <<< FRAC_BITS;
        sy = sy - 72'(qy_reg) * 72'($signed({1'b0, half_height}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st_in;
            for (int s = 1; s <= NS; s++)
            begin
                st_reg[s] <= st_nx[s-1];
            end
            qx_reg <= qx;
            qy_reg <= qy;
            fin_reg <= st_reg[NS];
            if (fin_reg.wz)
            begin
                res_reg <= {1'b1, {(4*DW){1'b0}}};
            end
            else
            begin
                res_reg <= {1'b0, fin_reg.tw, fin_reg.tz, sat_w(sy), sat_w(sx)};
            end
        end
    end

    assign out_valid = vld_reg[NS+2];
    assign out_data = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !q_ready) else $error("accept while stalled");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");

endmodule
